// ----- rtl/dscr_pkg.sv -----
// Shared types and constants for the DMX512 slot capture receiver.
// Used by dmx_slot_capture_receiver; depends on nothing else.

package dscr_pkg;

   localparam int unsigned SLOT_W       = 10;
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned TIMER_W      = 10;
   localparam int unsigned FRAMES_W     = 2;
   localparam int unsigned NUM_LEVELS   = 4;
   localparam int unsigned CSR_INDEX_W  = 3;
   localparam int unsigned CSR_DATA_W   = 10;

   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [BYTE_W-1:0]   byte_type;
   typedef logic [TIMER_W-1:0]  timer_type;
   typedef logic [FRAMES_W-1:0] frames_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;

   localparam csr_index_type REG_SLOT_ADDRESS_A = 3'd0;
   localparam csr_index_type REG_SLOT_ADDRESS_B = 3'd1;
   localparam csr_index_type REG_SLOT_ADDRESS_C = 3'd2;
   localparam csr_index_type REG_SLOT_ADDRESS_D = 3'd3;
   localparam csr_index_type REG_LOSS_LIMIT_MS  = 3'd4;

   localparam slot_type   SLOT_A_RESET     = 10'd1;
   localparam slot_type   SLOT_B_RESET     = 10'd2;
   localparam slot_type   SLOT_C_RESET     = 10'd3;
   localparam slot_type   SLOT_D_RESET     = 10'd4;
   localparam timer_type  LOSS_LIMIT_RESET = 10'd500;

   localparam byte_type   NULL_START       = 8'h00;
   localparam timer_type  LOSS_SAT         = 10'd1000;
   localparam frames_type FRAMES_FOR_READY = 2'd3;

   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

endpackage

// ----- rtl/dmx_slot_capture_receiver.sv -----
// DMX512 receiver top level: break and start-code tracking, slot patching and
// signal-loss supervision. Depends on dscr_pkg.
//
// Each item is one received UART byte with its overrun and framing flags, or a
// one-millisecond tick, and produces exactly one result item carrying the four
// captured levels, the ready flag and a frame-end marker. An item is taken into
// an input register, and all of its work (slot compare against the four patch
// addresses, end-of-frame detection, frame counting and loss timer update) is
// done combinationally on its way into the result register, so one item per
// cycle is sustained while rsp_ready does not stall the result register. The
// configuration port is always ready and takes effect on the next item.

module dmx_slot_capture_receiver #(
   parameter int unsigned CHANNELS = 4,
   parameter int unsigned MAX_SLOT = 512
) (
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_func,
   input  dscr_pkg::byte_type      req_rx_byte,
   input  logic                    req_overrun_error,
   input  logic                    req_framing_error,

   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output dscr_pkg::byte_type      rsp_level_a,
   output dscr_pkg::byte_type      rsp_level_b,
   output dscr_pkg::byte_type      rsp_level_c,
   output dscr_pkg::byte_type      rsp_level_d,
   output logic                    rsp_signal_ready,
   output logic                    rsp_frame_end,

   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  dscr_pkg::csr_index_type csr_index,
   input  dscr_pkg::csr_data_type  csr_data
);

   import dscr_pkg::*;

   typedef enum logic [1:0] {
      PH_WAIT_BREAK = 2'd0,
      PH_WAIT_START = 2'd1,
      PH_RECEIVING  = 2'd2
   } phase_type;

   localparam slot_type MAX_SLOT_V = SLOT_W'(MAX_SLOT);

   slot_type   slot_addr_ff [NUM_LEVELS];
   timer_type  loss_limit_ff;

   logic       in_valid_ff;
   logic       in_func_ff;
   byte_type   in_byte_ff;
   logic       in_oerr_ff;
   logic       in_ferr_ff;

   phase_type  phase_ff,   phase_in;
   slot_type   counter_ff, counter_in;
   byte_type   level_ff    [NUM_LEVELS];
   byte_type   level_in    [NUM_LEVELS];
   frames_type frames_ff,  frames_in;
   logic       ready_ff,   ready_in;
   timer_type  timer_ff,   timer_in;
   logic       done_in;

   logic       out_valid_ff;
   byte_type   out_level_ff [NUM_LEVELS];
   logic       out_ready_ff;
   logic       out_done_ff;

   logic       advance;
   slot_type   end_slot;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   always_comb begin
      end_slot = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (i < CHANNELS && slot_addr_ff[i] > end_slot) begin
            end_slot = slot_addr_ff[i];
         end
      end
      if (end_slot > MAX_SLOT_V) begin
         end_slot = MAX_SLOT_V;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      counter_in = counter_ff;
      level_in   = level_ff;
      frames_in  = frames_ff;
      ready_in   = ready_ff;
      timer_in   = timer_ff;
      done_in    = 1'b0;

      if (in_func_ff == FUNC_TICK) begin
         if (timer_ff < LOSS_SAT) begin
            timer_in = timer_ff + 1'b1;
         end
      end else if (in_oerr_ff) begin
         phase_in   = PH_WAIT_BREAK;
         counter_in = '0;
         frames_in  = '0;
         ready_in   = 1'b0;
      end else if (in_ferr_ff) begin
         phase_in   = PH_WAIT_START;
         counter_in = '0;
      end else begin
         unique case (phase_ff)
            PH_WAIT_START: begin
               if (in_byte_ff == NULL_START) begin
                  phase_in   = PH_RECEIVING;
                  counter_in = SLOT_W'(1);
               end else begin
                  phase_in  = PH_WAIT_BREAK;
                  frames_in = '0;
                  ready_in  = 1'b0;
               end
            end
            PH_RECEIVING: begin
               for (int i = 0; i < NUM_LEVELS; i++) begin
                  if (i < CHANNELS && counter_ff == slot_addr_ff[i]) begin
                     level_in[i] = in_byte_ff;
                  end
               end
               if (counter_ff >= end_slot) begin
                  timer_in = '0;
                  if (frames_ff < FRAMES_FOR_READY) begin
                     frames_in = frames_ff + 1'b1;
                  end
                  if (frames_in >= FRAMES_FOR_READY) begin
                     ready_in = 1'b1;
                  end
                  phase_in = PH_WAIT_BREAK;
                  done_in  = 1'b1;
               end
               counter_in = counter_ff + 1'b1;
            end
            default: begin
            end
         endcase
      end

      if (timer_in >= loss_limit_ff) begin
         ready_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_addr_ff[0] <= SLOT_A_RESET;
         slot_addr_ff[1] <= SLOT_B_RESET;
         slot_addr_ff[2] <= SLOT_C_RESET;
         slot_addr_ff[3] <= SLOT_D_RESET;
         loss_limit_ff   <= LOSS_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_SLOT_ADDRESS_A: slot_addr_ff[0] <= csr_data;
            REG_SLOT_ADDRESS_B: slot_addr_ff[1] <= csr_data;
            REG_SLOT_ADDRESS_C: slot_addr_ff[2] <= csr_data;
            REG_SLOT_ADDRESS_D: slot_addr_ff[3] <= csr_data;
            REG_LOSS_LIMIT_MS:  loss_limit_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_func_ff <= req_func;
         in_byte_ff <= req_rx_byte;
         in_oerr_ff <= req_overrun_error;
         in_ferr_ff <= req_framing_error;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_WAIT_BREAK;
         counter_ff <= '0;
         level_ff   <= '{default: '0};
         frames_ff  <= '0;
         ready_ff   <= 1'b0;
         timer_ff   <= '0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         counter_ff <= counter_in;
         level_ff   <= level_in;
         frames_ff  <= frames_in;
         ready_ff   <= ready_in;
         timer_ff   <= timer_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            out_level_ff[i] <= (i < CHANNELS) ? level_in[i] : '0;
         end
         out_ready_ff <= ready_in;
         out_done_ff  <= done_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_level_a      = out_level_ff[0];
   assign rsp_level_b      = out_level_ff[1];
   assign rsp_level_c      = out_level_ff[2];
   assign rsp_level_d      = out_level_ff[3];
   assign rsp_signal_ready = out_ready_ff;
   assign rsp_frame_end    = out_done_ff;

endmodule
